[src/otsu_pkg.sv]
`timescale 1ns / 1ps

package otsu_pkg;

	// Histogram geometry
	localparam int COUNT_BITS = 22;
	localparam int BIN_BITS   = 8;
	localparam int NBINS      = 1 << BIN_BITS;

	// Sweep arithmetic widths: pixel total, weighted sum, difference term,
	// its square, class product and the cross-multiplied compare
	localparam int NW  = COUNT_BITS + BIN_BITS;
	localparam int SW  = NW + BIN_BITS;
	localparam int DW  = SW + NW;
	localparam int D2W = 2 * DW;
	localparam int PW  = 2 * NW;
	localparam int CW  = D2W + PW;

	// Shared serial multiplier operand and product widths
	localparam int MUL_AW = D2W;
	localparam int MUL_BW = DW;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	// Pixel queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR   = 2;

	typedef logic [BIN_BITS-1:0]   bin_t;
	typedef logic [COUNT_BITS-1:0] cnt_t;

	localparam cnt_t              CNT_MAX  = '1;
	localparam bin_t              BIN_LAST = bin_t'(NBINS - 1);
	localparam logic [Q_PTR:0]    Q_FULL   = (Q_PTR + 1)'(Q_DEPTH);

	typedef struct packed {
		bin_t pixel;
		logic last;
	} pix_item_t;

	typedef struct packed {
		logic      valid;
		pix_item_t item;
	} q_head_t;

	typedef struct packed {
		logic              start;
		logic [MUL_AW-1:0] a;
		logic [MUL_BW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [MUL_PW-1:0] prod;
	} mul_rsp_t;

endpackage

[src/otsu_pix_if.sv]
`timescale 1ns / 1ps

interface otsu_pix_if;
	logic          valid;
	logic          ready;
	otsu_pkg::bin_t pixel;
	logic          last_pixel;

	modport source (output valid, output pixel, output last_pixel, input ready);
	modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

[src/otsu_res_if.sv]
`timescale 1ns / 1ps

interface otsu_res_if;
	logic          valid;
	logic          ready;
	otsu_pkg::bin_t threshold;
	logic          overflow;

	modport source (output valid, output threshold, output overflow, input ready);
	modport sink   (input valid, input threshold, input overflow, output ready);
endinterface

[src/otsu_front.sv]
`timescale 1ns / 1ps

module otsu_front (
	input  logic              clk,
	input  logic              arst_n,
	otsu_pix_if.sink          pixels,
	output otsu_pkg::q_head_t head,
	input  logic              pop
);
	import otsu_pkg::*;

	pix_item_t      slot_q [Q_DEPTH];
	logic [Q_PTR-1:0] wr_ptr_q;
	logic [Q_PTR-1:0] rd_ptr_q;
	logic [Q_PTR:0]   fill_q;
	logic             push;

	// Accept while the queue has room
	assign pixels.ready = (fill_q != Q_FULL);
	assign push         = pixels.valid && pixels.ready;

	// Present the oldest pixel and its end-of-image mark to the back end
	assign head.valid = (fill_q != '0);
	assign head.item  = slot_q[rd_ptr_q];

	// Store the accepted pixel
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{pixel: pixels.pixel, last: pixels.last_pixel};
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[src/otsu_mul.sv]
`timescale 1ns / 1ps

module otsu_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  otsu_pkg::mul_req_t req,
	output otsu_pkg::mul_rsp_t rsp
);
	import otsu_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [MUL_PW-1:0] acc_q;
	logic [MUL_PW-1:0] a_q;
	logic [MUL_BW-1:0] b_q;
	logic              last_step;

	// Finish once no set multiplier bit remains above the current one
	assign last_step = ((b_q >> 1) == '0);

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

	// Control: run until the multiplier is exhausted, then pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last_step) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Shift-add: one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= MUL_PW'(req.a);
			b_q   <= req.b;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

endmodule

[src/otsu_back.sv]
`timescale 1ns / 1ps

module otsu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  otsu_pkg::q_head_t  head,
	output logic               pop,
	output otsu_pkg::mul_req_t mreq,
	input  otsu_pkg::mul_rsp_t mrsp,
	otsu_res_if.source         results
);
	import otsu_pkg::*;

	typedef enum logic [3:0] {
		ST_ACC,
		ST_TOT_RD,
		ST_TOT_ADD,
		ST_BIN_RD,
		ST_BIN_UPD,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_D2,
		ST_MUL_P,
		ST_MUL_L,
		ST_MUL_R,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t step_st;

	// Histogram memory and per-bin valid bits
	cnt_t             hist_mem [NBINS];
	cnt_t             rdata_q;
	bin_t             rd_addr;
	logic [NBINS-1:0] hvld_q;

	// Accumulate pipeline
	logic stop_q;
	logic v_s1;
	logic last_s1;
	bin_t pix_s1;
	logic fwd_q;
	bin_t fwd_addr_q;
	cnt_t fwd_data_q;
	cnt_t cnt_cur;
	cnt_t cnt_new;
	logic sat;
	logic ovf_q;

	// Sweep datapath
	bin_t            idx_q;
	logic            last_bin;
	cnt_t            h_bin;
	logic [NW-1:0]   wh;
	logic [NW-1:0]   n_q;
	logic [NW-1:0]   n0_q;
	logic [NW-1:0]   n0_nx;
	logic [NW-1:0]   n1_nx;
	logic [NW-1:0]   n1_cur;
	logic [SW-1:0]   s_q;
	logic [SW-1:0]   s0_q;
	logic [SW-1:0]   s0_nx;
	logic [DW-1:0]   x_q;
	logic [DW-1:0]   y_val;
	logic [DW-1:0]   d_nx;
	logic [D2W-1:0]  d2_q;
	logic [D2W-1:0]  best_d2_q;
	logic [PW-1:0]   p_q;
	logic [PW-1:0]   best_p_q;
	logic [CW-1:0]   lhs_q;
	logic            have_q;
	bin_t            best_t_q;

	// Multiplier request registers
	logic              start_q;
	logic [MUL_AW-1:0] ma_q;
	logic [MUL_BW-1:0] mb_q;

	// Result register
	logic res_vld_q;
	bin_t res_thr_q;
	logic res_ovf_q;

	assign mreq = '{start: start_q, a: ma_q, b: mb_q};

	assign results.valid     = res_vld_q;
	assign results.threshold = res_thr_q;
	assign results.overflow  = res_ovf_q;

	// Take pixels only while counting and before the end of the image
	assign pop     = (state_q == ST_ACC) && head.valid && !stop_q;
	assign rd_addr = (state_q == ST_ACC) ? head.item.pixel : idx_q;

	// Bin update: forward the write of the previous cycle, saturate at max
	always_comb begin
		if (fwd_q && (fwd_addr_q == pix_s1)) begin
			cnt_cur = fwd_data_q;
		end else if (hvld_q[pix_s1]) begin
			cnt_cur = rdata_q;
		end else begin
			cnt_cur = '0;
		end
		sat     = (cnt_cur == CNT_MAX);
		cnt_new = sat ? cnt_cur : cnt_cur + 1'b1;
	end

	// Sweep arithmetic of the current bin
	assign last_bin = (idx_q == BIN_LAST);
	assign step_st  = last_bin ? ST_DONE : ST_BIN_RD;
	assign h_bin    = hvld_q[idx_q] ? rdata_q : '0;
	assign wh       = NW'(idx_q) * NW'(h_bin);
	assign n0_nx    = n0_q + NW'(h_bin);
	assign s0_nx    = s0_q + SW'(wh);
	assign n1_nx    = n_q - n0_nx;
	assign n1_cur   = n_q - n0_q;
	assign y_val    = mrsp.prod[DW-1:0];
	assign d_nx     = (x_q >= y_val) ? (x_q - y_val) : (y_val - x_q);

	// Histogram memory: one read and one write port
	always_ff @(posedge clk) begin
		rdata_q <= hist_mem[rd_addr];
		if (v_s1) hist_mem[pix_s1] <= cnt_new;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_ACC;
			stop_q    <= 1'b0;
			v_s1      <= 1'b0;
			fwd_q     <= 1'b0;
			hvld_q    <= '0;
			ovf_q     <= 1'b0;
			idx_q     <= '0;
			have_q    <= 1'b0;
			start_q   <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			v_s1    <= pop;
			fwd_q   <= v_s1;
			if (pop && head.item.last) stop_q <= 1'b1;
			if (results.ready) res_vld_q <= 1'b0;
			if (v_s1) begin
				hvld_q[pix_s1] <= 1'b1;
				if (sat) ovf_q <= 1'b1;
			end
			unique case (state_q)
				ST_ACC: begin
					if (v_s1 && last_s1) begin
						state_q <= ST_TOT_RD;
						idx_q   <= '0;
					end
				end
				ST_TOT_RD: state_q <= ST_TOT_ADD;
				ST_TOT_ADD: begin
					idx_q <= idx_q + 1'b1;
					if (last_bin) begin
						state_q <= ST_BIN_RD;
						have_q  <= 1'b0;
					end else begin
						state_q <= ST_TOT_RD;
					end
				end
				ST_BIN_RD: state_q <= ST_BIN_UPD;
				ST_BIN_UPD: begin
					// Stop once class 1 is empty, skip while class 0 is empty
					if (n1_nx == '0) begin
						state_q <= ST_DONE;
					end else if (n0_nx == '0) begin
						state_q <= step_st;
						idx_q   <= idx_q + 1'b1;
					end else begin
						start_q <= 1'b1;
						state_q <= ST_MUL_X;
					end
				end
				ST_MUL_X: begin
					if (mrsp.done) begin
						start_q <= 1'b1;
						state_q <= ST_MUL_Y;
					end
				end
				ST_MUL_Y: begin
					if (mrsp.done) begin
						start_q <= 1'b1;
						state_q <= ST_MUL_D2;
					end
				end
				ST_MUL_D2: begin
					if (mrsp.done) begin
						start_q <= 1'b1;
						state_q <= ST_MUL_P;
					end
				end
				ST_MUL_P: begin
					if (mrsp.done) begin
						if (!have_q) begin
							have_q  <= 1'b1;
							state_q <= step_st;
							idx_q   <= idx_q + 1'b1;
						end else begin
							start_q <= 1'b1;
							state_q <= ST_MUL_L;
						end
					end
				end
				ST_MUL_L: begin
					if (mrsp.done) begin
						start_q <= 1'b1;
						state_q <= ST_MUL_R;
					end
				end
				ST_MUL_R: begin
					if (mrsp.done) begin
						state_q <= step_st;
						idx_q   <= idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					// Publish, then clear the histogram and the sticky flag
					if (!res_vld_q || results.ready) begin
						res_vld_q <= 1'b1;
						hvld_q    <= '0;
						ovf_q     <= 1'b0;
						stop_q    <= 1'b0;
						state_q   <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		pix_s1     <= head.item.pixel;
		last_s1    <= head.item.last;
		fwd_addr_q <= pix_s1;
		fwd_data_q <= cnt_new;
		unique case (state_q)
			ST_ACC: begin
				n_q <= '0;
				s_q <= '0;
			end
			ST_TOT_ADD: begin
				n_q      <= n_q + NW'(h_bin);
				s_q      <= s_q + SW'(wh);
				n0_q     <= '0;
				s0_q     <= '0;
				best_t_q <= '0;
			end
			ST_BIN_UPD: begin
				n0_q <= n0_nx;
				s0_q <= s0_nx;
				ma_q <= MUL_AW'(s0_nx);
				mb_q <= MUL_BW'(n_q);
			end
			ST_MUL_X: begin
				x_q  <= mrsp.prod[DW-1:0];
				ma_q <= MUL_AW'(s_q);
				mb_q <= MUL_BW'(n0_q);
			end
			ST_MUL_Y: begin
				ma_q <= MUL_AW'(d_nx);
				mb_q <= d_nx;
			end
			ST_MUL_D2: begin
				d2_q <= mrsp.prod[D2W-1:0];
				ma_q <= MUL_AW'(n0_q);
				mb_q <= MUL_BW'(n1_cur);
			end
			ST_MUL_P: begin
				p_q  <= mrsp.prod[PW-1:0];
				ma_q <= d2_q;
				mb_q <= MUL_BW'(best_p_q);
				if (mrsp.done && !have_q) begin
					best_d2_q <= d2_q;
					best_p_q  <= mrsp.prod[PW-1:0];
					best_t_q  <= idx_q;
				end
			end
			ST_MUL_L: begin
				lhs_q <= mrsp.prod[CW-1:0];
				ma_q  <= best_d2_q;
				mb_q  <= MUL_BW'(p_q);
			end
			ST_MUL_R: begin
				// Keep the new bin only on a strictly larger score
				if (mrsp.done && (lhs_q > mrsp.prod[CW-1:0])) begin
					best_d2_q <= d2_q;
					best_p_q  <= p_q;
					best_t_q  <= idx_q;
				end
			end
			ST_DONE: begin
				if (!res_vld_q || results.ready) begin
					res_thr_q <= best_t_q;
					res_ovf_q <= ovf_q;
				end
			end
			default: begin
				ma_q <= ma_q;
			end
		endcase
	end

endmodule

[src/otsu_threshold_core.sv]
`timescale 1ns / 1ps

// Otsu threshold of 8-bit gray images. Pixels enter on the pixels channel at one per
// cycle while the queue has room into a 4-deep queue and are counted into a 256-bin
// histogram (22-bit bins that saturate and raise overflow). The transaction marked
// last_pixel closes the image: the back end then runs a totals pass (one memory read
// and one add per bin) and a threshold sweep that, for every bin where both classes
// hold pixels, forms four products on one shared shift-add multiplier, and two more to
// compare against the best bin once one is held. The multiplier works through one
// multiplier bit per cycle and stops after its highest set bit. During the sweep the
// next image's pixels fill the queue and then stall. The threshold and overflow flag
// wait in an output register; the histogram clears at once through per-bin valid
// bits, with no clearing pass.
module otsu_threshold_core (
	input  logic       clk,
	input  logic       arst_n,
	otsu_pix_if.sink   pixels,
	otsu_res_if.source results
);
	import otsu_pkg::*;

	q_head_t  head;
	logic     pop;
	mul_req_t mreq;
	mul_rsp_t mrsp;

	// Accept and queue pixels
	otsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pixels),
		.head   (head),
		.pop    (pop)
	);

	// Count, sweep and publish the threshold
	otsu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.mreq    (mreq),
		.mrsp    (mrsp),
		.results (results)
	);

	// Shared serial multiplier of the sweep
	otsu_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

endmodule

[src/otsu_chk.sv]
`timescale 1ns / 1ps

module otsu_chk (
	input logic        clk,
	input logic        arst_n,
	otsu_pix_if.sink   pixels,
	otsu_res_if.source results
);

	logic [3:0] pend_q;
	logic       last_in;
	logic       res_out;

	assign last_in = pixels.valid && pixels.ready && pixels.last_pixel;
	assign res_out = results.valid && results.ready;

	// Track images closed but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 4'(last_in) - 4'(res_out);
		end
	end

	// Hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |=> results.valid)
		else $error("result dropped while stalled");

	// Keep a stalled result's payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |=>
			$stable(results.threshold) && $stable(results.overflow))
		else $error("result payload changed while stalled");

	// Every result belongs to a closed image
	a_res_pending: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> pend_q != 4'd0)
		else $error("result without a closed image");

	// A freshly closed image cannot be answered in the next cycle
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		last_in && pend_q == 4'd0 |=> !results.valid)
		else $error("result appeared before the sweep could run");

endmodule

bind otsu_threshold_core otsu_chk u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.pixels  (pixels),
	.results (results)
);
